@@ design/bba_pkg.sv @@
// Shared types and codes for the buddy block allocator.
package bba_pkg;

	localparam int OUT_W = 14;
	localparam int SIZE_W = 16;

	localparam logic [1:0] ST_GRANTED   = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
	localparam logic [1:0] ST_NO_MEMORY = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SIZE   = 5'b00010,
		S_SEARCH = 5'b00100,
		S_SPLIT  = 5'b01000,
		S_DONE   = 5'b10000
	} seq_state_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] status;
	} res_t;

endpackage

@@ design/bba_unit.sv @@
// Shared power-of-two unit: size compare and buddy offset add for one level.
module bba_unit #(
	parameter int HEAP_LOG2 = 14
) (
	input  logic [$clog2(HEAP_LOG2+1)-1:0] lvl,
	input  logic [bba_pkg::SIZE_W-1:0]     size,
	input  logic [HEAP_LOG2-1:0]           base,
	output logic                           below,
	output logic [HEAP_LOG2-1:0]           sum
);
	import bba_pkg::*;

	localparam int CW = (HEAP_LOG2 + 1 > SIZE_W + 1) ? HEAP_LOG2 + 1 : SIZE_W + 1;

	logic [CW-1:0] pow;

	assign pow   = CW'(1) << lvl;
	assign below = pow < CW'(size);
	assign sum   = base + HEAP_LOG2'(pow);

endmodule

@@ design/bba_seq.sv @@
// Sequencer and per-level free state: level pick, upward search, split walk.
module bba_seq #(
	parameter int HEAP_LOG2 = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bba_pkg::SIZE_W-1:0] request_size,
	input  logic                       take,
	output bba_pkg::res_t              res,
	output logic [HEAP_LOG2-1:0]       res_offset
);
	import bba_pkg::*;

	localparam int LEVELS = HEAP_LOG2 + 1;
	localparam int LW = $clog2(LEVELS);
	localparam logic [LW-1:0] TOP = LW'(HEAP_LOG2);
	localparam logic [SIZE_W:0] HEAP_LIM =
		(HEAP_LOG2 >= SIZE_W) ? (SIZE_W+1)'(1 << SIZE_W) : (SIZE_W+1)'(1 << HEAP_LOG2);

	seq_state_t               state_q;
	logic [LW-1:0]            cnt_q;
	logic [LW-1:0]            want_q;
	logic [SIZE_W-1:0]        size_q;
	logic [HEAP_LOG2-1:0]     base_q;
	logic [1:0]               status_q;
	logic [LEVELS-1:0]        has_free_q;
	logic [HEAP_LOG2-1:0]     free_off_q [LEVELS];

	logic [LW-1:0]            cnt_dn;
	logic [LW-1:0]            unit_lvl;
	logic                     below;
	logic [HEAP_LOG2-1:0]     split_off;
	logic                     bad_size;

	assign cnt_dn   = cnt_q - 1'b1;
	assign unit_lvl = (state_q == S_SPLIT) ? cnt_dn : cnt_q;
	assign bad_size = (request_size == '0) || ({1'b0, request_size} > HEAP_LIM);

	bba_unit #(
		.HEAP_LOG2(HEAP_LOG2)
	) u_unit (
		.lvl  (unit_lvl),
		.size (size_q),
		.base (base_q),
		.below(below),
		.sum  (split_off)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			want_q     <= '0;
			status_q   <= ST_GRANTED;
			base_q     <= '0;
			has_free_q <= LEVELS'(1) << HEAP_LOG2;
			for (int i = 0; i < LEVELS; i++) free_off_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						if (bad_size) begin
							status_q <= ST_BAD_SIZE;
							base_q   <= '0;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SIZE;
						end
					end
				end
				S_SIZE: begin
					if (cnt_q != TOP && below) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						want_q  <= cnt_q;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (has_free_q[cnt_q]) begin
						has_free_q[cnt_q] <= 1'b0;
						base_q            <= free_off_q[cnt_q];
						status_q          <= ST_GRANTED;
						state_q           <= (cnt_q == want_q) ? S_DONE : S_SPLIT;
					end else if (cnt_q == TOP) begin
						status_q <= ST_NO_MEMORY;
						base_q   <= '0;
						state_q  <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SPLIT: begin
					has_free_q[cnt_dn] <= 1'b1;
					free_off_q[cnt_dn] <= split_off;
					cnt_q              <= cnt_dn;
					if (cnt_dn == want_q) state_q <= S_DONE;
				end
				S_DONE: begin
					if (take) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the size of the word in flight
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) size_q <= request_size;
	end

	assign in_stall   = (state_q != S_IDLE);
	assign res.valid  = (state_q == S_DONE);
	assign res.status = status_q;
	assign res_offset = base_q;

endmodule

@@ design/buddy_block_allocator.sv @@
// Allocate-only buddy allocator over a heap of 2^HEAP_LOG2 bytes. One request word
// gives a byte count; one result word gives the granted offset and a status
// (granted, bad size, out of memory). After a request is accepted the block is busy
// until its result is taken: a bad size goes straight to the result; otherwise one
// shared power-of-two unit walks the levels one per cycle, first up to the fitting
// level, then up to the nearest free level (or the top level when none is free),
// then back down while splitting. Input stall stays high for the whole walk; a
// finished result moves into the output register, so the next request is taken while
// it waits there, and only a result still held in that register delays the end of
// the walk.
module buddy_block_allocator #(
	parameter int HEAP_LOG2 = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bba_pkg::SIZE_W-1:0] request_size,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bba_pkg::OUT_W-1:0]  block_offset,
	output logic [1:0]                 grant_status
);
	import bba_pkg::*;

	res_t                 res;
	logic [HEAP_LOG2-1:0] res_offset;
	logic                 take;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     block_offset_q;
	logic [1:0]           grant_status_q;

	bba_seq #(
		.HEAP_LOG2(HEAP_LOG2)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.request_size(request_size),
		.take        (take),
		.res         (res),
		.res_offset  (res_offset)
	);

	assign take = res.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			block_offset_q <= OUT_W'(res_offset);
			grant_status_q <= res.status;
		end
	end

	assign out_valid    = out_valid_q;
	assign block_offset = block_offset_q;
	assign grant_status = grant_status_q;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (grant_status == ST_GRANTED || grant_status == ST_BAD_SIZE ||
			grant_status == ST_NO_MEMORY))
		else $error("undefined grant status");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grant_status != ST_GRANTED |-> block_offset == '0)
		else $error("nonzero offset on refused request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still in progress");

endmodule
